### rtl/fatl_pkg.sv
`timescale 1ns / 1ps

package fatl_pkg;

  localparam int NUM_LINES      = 16;
  localparam int IDX_W          = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int CNT_W          = $clog2(NUM_LINES + 1);

  localparam int ADDR_W         = 32;
  localparam int LINE_W         = 4;
  localparam int LIU_W          = 5;
  localparam int BS_W           = 13;
  localparam int OFF_W          = 12;
  localparam int MAX_BLOCK_SIZE = 4096;

  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 13;

  localparam int IN_DATA_BITS   = ADDR_W + LINE_W + ADDR_W;
  localparam int IN_TDATA_W     = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS  = LINE_W + ADDR_W + OFF_W;
  localparam int OUT_TDATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

  localparam int DIV_STEPS      = ADDR_W;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS + 1);

  localparam logic [LIU_W-1:0] LIU_RESET = LIU_W'(16);
  localparam logic [BS_W-1:0]  BS_RESET  = BS_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINES_IN_USE = 8'd0,
    CFG_BLOCK_SIZE   = 8'd1
  } cfg_reg_t;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_FILL   = 1'b1
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [ADDR_W-1:0] wr_tag;
  } tag_wr_t;

endpackage

### rtl/fatl_div.sv
`timescale 1ns / 1ps

module fatl_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fatl_pkg::ADDR_W-1:0] dividend,
  input  logic [fatl_pkg::BS_W-1:0]   divisor,
  output fatl_pkg::div_stat_t         stat,
  output logic [fatl_pkg::ADDR_W-1:0] quotient,
  output logic [fatl_pkg::OFF_W-1:0]  remainder
);
  import fatl_pkg::*;

  logic [ADDR_W-1:0]    quo_r, quo_nxt;
  logic [BS_W-1:0]      rem_r, rem_nxt;
  logic [BS_W-1:0]      dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [BS_W:0]        shifted;
  logic [BS_W:0]        diff;

  assign shifted = {rem_r, quo_r[ADDR_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = DIV_CNT_W'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = diff[BS_W-1:0];
        quo_nxt = {quo_r[ADDR_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[BS_W-1:0];
        quo_nxt = {quo_r[ADDR_W-2:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r[OFF_W-1:0];

endmodule

### rtl/fatl_tags.sv
`timescale 1ns / 1ps

module fatl_tags (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fatl_pkg::tag_wr_t           wr,
  input  logic [fatl_pkg::ADDR_W-1:0] key,
  input  logic [fatl_pkg::CNT_W-1:0]  n_lines,
  output logic                        hit,
  output logic [fatl_pkg::LINE_W-1:0] hit_line
);
  import fatl_pkg::*;

  logic [NUM_LINES-1:0] valid_r, valid_nxt;
  logic [ADDR_W-1:0]    tag_r [NUM_LINES];
  logic [NUM_LINES-1:0] match;

  always_comb begin
    valid_nxt = valid_r;
    if (wr.wr_en) begin
      valid_nxt[wr.wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (wr.wr_en) begin
      tag_r[wr.wr_idx] <= wr.wr_tag;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_LINES; i++) begin
      match[i] = valid_r[i] && (tag_r[i] == key) && (i < int'(n_lines));
    end
  end

  always_comb begin
    hit      = 1'b0;
    hit_line = '0;
    for (int i = NUM_LINES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit      = 1'b1;
        hit_line = LINE_W'(i);
      end
    end
  end

endmodule

### rtl/fully_associative_tag_lookup.sv
`timescale 1ns / 1ps

// Tag store of a one-set fully associative cache.
// Input channel (in_*): one transaction per command. in_tuser is the command
// (lookup or fill); in_tdata carries the address, the fill line and the fill
// block number. Every command returns exactly one result transaction.
// Lookup: the address is split by the configured block size into block number
// and offset, then the valid lines in use are compared against the block
// number and the lowest matching line is reported. Fill: the block number is
// stored as the tag of the given line and the line is marked valid; the result
// is all zero.
// A lookup runs the address through the restoring divider, which retires one
// quotient bit per cycle, before the tag compare; a fill needs no division.
// in_tready is low from acceptance until the result is in the output register,
// so no new command is accepted before the previous result has been registered.
// A finished result sits in the output register until out_tready; the next
// command is accepted meanwhile, and its result waits until that register frees.
// Configuration (cfg_*): index 0 is lines in use, index 1 is block size; write
// only while no command is outstanding. cfg_ready is always high.
// Reset (rst_n low, synchronous): all lines invalid, registers back to 16 lines
// and 16-byte blocks, no result pending.
module fully_associative_tag_lookup (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [31:0] address, [35:32] fill_line, [67:36] fill_block, [71:68] zero
  input  logic [fatl_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] command
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [3:0] hit_line, [35:4] block_number, [47:36] offset
  output logic [fatl_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] hit
  output logic                             out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fatl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fatl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fatl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [LIU_W-1:0]  liu_r, liu_nxt;
  logic [BS_W-1:0]   bs_r, bs_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic [LINE_W-1:0] out_line_r, out_line_nxt;
  logic [ADDR_W-1:0] out_blk_r, out_blk_nxt;
  logic [OFF_W-1:0]  out_off_r, out_off_nxt;

  logic              in_fire;
  logic              out_free;
  logic [ADDR_W-1:0] in_address;
  logic [LINE_W-1:0] in_fill_line;
  logic [ADDR_W-1:0] in_fill_block;
  logic [BS_W-1:0]   bs_eff;
  logic [CNT_W-1:0]  lines_eff;
  logic              div_start;
  div_stat_t         div_stat;
  logic [ADDR_W-1:0] quotient;
  logic [OFF_W-1:0]  remainder;
  tag_wr_t           tag_wr;
  logic              tag_hit;
  logic [LINE_W-1:0] tag_line;

  assign in_address    = in_tdata[ADDR_W-1:0];
  assign in_fill_line  = in_tdata[ADDR_W +: LINE_W];
  assign in_fill_block = in_tdata[ADDR_W+LINE_W +: ADDR_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (bs_r == '0) begin
      bs_eff = BS_W'(1);
    end else if (int'(bs_r) > MAX_BLOCK_SIZE) begin
      bs_eff = BS_W'(MAX_BLOCK_SIZE);
    end else begin
      bs_eff = bs_r;
    end
    if (liu_r == '0) begin
      lines_eff = CNT_W'(1);
    end else if (int'(liu_r) > NUM_LINES) begin
      lines_eff = CNT_W'(NUM_LINES);
    end else begin
      lines_eff = CNT_W'(liu_r);
    end
  end

  assign div_start     = in_fire && (cmd_t'(in_tuser) == CMD_LOOKUP);
  assign tag_wr.wr_en  = in_fire && (cmd_t'(in_tuser) == CMD_FILL)
                         && (int'(in_fill_line) < NUM_LINES);
  assign tag_wr.wr_idx = IDX_W'(in_fill_line);
  assign tag_wr.wr_tag = in_fill_block;

  fatl_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_address),
    .divisor   (bs_eff),
    .stat      (div_stat),
    .quotient  (quotient),
    .remainder (remainder)
  );

  fatl_tags u_tags (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (tag_wr),
    .key      (quotient),
    .n_lines  (lines_eff),
    .hit      (tag_hit),
    .hit_line (tag_line)
  );

  always_comb begin
    liu_nxt = liu_r;
    bs_nxt  = bs_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LINES_IN_USE: liu_nxt = cfg_data[LIU_W-1:0];
        CFG_BLOCK_SIZE:   bs_nxt  = cfg_data[BS_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    out_line_nxt  = out_line_r;
    out_blk_nxt   = out_blk_r;
    out_off_nxt   = out_off_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = cmd_t'(in_tuser);
          state_nxt = (cmd_t'(in_tuser) == CMD_LOOKUP) ? ST_DIV : ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (cmd_r == CMD_LOOKUP) begin
            out_hit_nxt  = tag_hit;
            out_line_nxt = tag_line;
            out_blk_nxt  = quotient;
            out_off_nxt  = remainder;
          end else begin
            out_hit_nxt  = 1'b0;
            out_line_nxt = '0;
            out_blk_nxt  = '0;
            out_off_nxt  = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmd_r       <= CMD_LOOKUP;
      liu_r       <= LIU_RESET;
      bs_r        <= BS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      liu_r       <= liu_nxt;
      bs_r        <= bs_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_hit_r  <= out_hit_nxt;
    out_line_r <= out_line_nxt;
    out_blk_r  <= out_blk_nxt;
    out_off_r  <= out_off_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = OUT_TDATA_W'({out_off_r, out_blk_r, out_line_r});

endmodule

### rtl/fatl_checker.sv
`timescale 1ns / 1ps

module fatl_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [fatl_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser
);
  import fatl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result transaction dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("new transaction accepted while a command is in flight");

  a_miss_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[LINE_W-1:0] == '0)
    else $error("miss or fill reports a nonzero line");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset leaves a result pending or the input blocked");

endmodule

bind fully_associative_tag_lookup fatl_checker u_fatl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
